@@ sv/nmea_sentence_framer_checksum_macros.svh @@
// Assertion macros shared by the sentence framer RTL.
// Depends on nothing; modules include it and need i_clk and i_rst_n in scope.
`ifndef NMEA_SENTENCE_FRAMER_CHECKSUM_MACROS_SVH
`define NMEA_SENTENCE_FRAMER_CHECKSUM_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define NSFC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nsfc assertion failed");

// Next-cycle implication, checked out of reset.
`define NSFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nsfc assertion failed");

`endif

@@ sv/nsfc_pkg.sv @@
// Package for the NMEA sentence framer: types, character codes, helpers.
// Depends on nothing; used by every module of the block.
`default_nettype none

package nsfc_pkg;

    localparam int DEF_MAX_SENTENCE_LENGTH = 80;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_F      = 8'h46;

    localparam logic [7:0] TALKER_FIRST_RESET  = 8'h47;
    localparam logic [7:0] TALKER_SECOND_RESET = 8'h50;

    localparam logic CFG_TALKER_FIRST  = 1'b0;
    localparam logic CFG_TALKER_SECOND = 1'b1;

    localparam logic [1:0] TYPE_GGA   = 2'd0;
    localparam logic [1:0] TYPE_GSV   = 2'd1;
    localparam logic [1:0] TYPE_RMC   = 2'd2;
    localparam logic [1:0] TYPE_OTHER = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_TALK1   = 3'd1,
        PH_TALK2   = 3'd2,
        PH_TYPE0   = 3'd3,
        PH_TYPE1   = 3'd4,
        PH_TYPE2   = 3'd5,
        PH_BODY    = 3'd6,
        PH_WAIT_LF = 3'd7
    } t_phase;

    typedef struct packed {
        logic [1:0] sentence_type;
        logic       checksum_ok;
        logic [7:0] computed_checksum;
    } t_result;

    // Bit 4 set marks a character that is not an uppercase hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= CH_0 && c <= CH_9) begin
                d = c - CH_0;
                hex_value = {1'b0, d[3:0]};
            end else if (c >= CH_A && c <= CH_F) begin
                d = c - CH_A + 8'd10;
                hex_value = {1'b0, d[3:0]};
            end else begin
                hex_value = 5'h10;
            end
        end
    endfunction

    function automatic logic [1:0] classify(input logic [7:0] c0, input logic [7:0] c1,
                                            input logic [7:0] c2);
        begin
            if (c0 == CH_G && c1 == CH_G && c2 == CH_A) begin
                classify = TYPE_GGA;
            end else if (c0 == CH_G && c1 == CH_S && c2 == CH_V) begin
                classify = TYPE_GSV;
            end else if (c0 == CH_R && c1 == CH_M && c2 == CH_C) begin
                classify = TYPE_RMC;
            end else begin
                classify = TYPE_OTHER;
            end
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/nsfc_framer.sv @@
// Sentence framer: phase tracking, running XOR, type capture and result logic.
// Depends on nsfc_pkg and nmea_sentence_framer_checksum_macros.svh.
`default_nettype none

module nsfc_framer #(
    parameter int MAX_SENTENCE_LENGTH = nsfc_pkg::DEF_MAX_SENTENCE_LENGTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_byte,
    input  wire logic [7:0]       i_talker_first,
    input  wire logic [7:0]       i_talker_second,
    output logic                  o_res_valid,
    output nsfc_pkg::t_result     o_res
);
    import nsfc_pkg::*;
    `include "nmea_sentence_framer_checksum_macros.svh"

    localparam int CW = $clog2(MAX_SENTENCE_LENGTH + 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_SENTENCE_LENGTH);

    t_phase        r_phase, n_phase;
    logic [7:0]    r_xor, n_xor;
    logic          r_star, n_star;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_recent0, n_recent0;
    logic [7:0]    r_recent1, n_recent1;
    logic [7:0]    r_type0, r_type1, r_type2;

    logic          is_dollar;
    logic          do_capture;
    logic [4:0]    hex_hi, hex_lo;

    assign is_dollar = (i_byte == CH_DOLLAR);

    always_comb begin
        n_phase = r_phase;
        if (i_valid) begin
            if (is_dollar) begin
                n_phase = PH_TALK1;
            end else begin
                unique case (r_phase)
                    PH_HUNT:    n_phase = PH_HUNT;
                    PH_TALK1:   n_phase = (i_byte == i_talker_first) ? PH_TALK2 : PH_HUNT;
                    PH_TALK2:   n_phase = (i_byte == i_talker_second) ? PH_TYPE0 : PH_HUNT;
                    PH_TYPE0:   n_phase = PH_TYPE1;
                    PH_TYPE1:   n_phase = PH_TYPE2;
                    PH_TYPE2:   n_phase = PH_BODY;
                    PH_BODY: begin
                        if (i_byte == CH_CR) begin
                            n_phase = PH_WAIT_LF;
                        end else if (i_byte == CH_LF || r_count >= MAX_COUNT) begin
                            n_phase = PH_HUNT;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end
                    PH_WAIT_LF: n_phase = PH_HUNT;
                    default:    n_phase = PH_HUNT;
                endcase
            end
        end
    end

    always_comb begin
        do_capture = 1'b0;
        case (r_phase)
            PH_TALK1:                   do_capture = (i_byte == i_talker_first);
            PH_TALK2:                   do_capture = (i_byte == i_talker_second);
            PH_TYPE0, PH_TYPE1, PH_TYPE2: do_capture = 1'b1;
            PH_BODY:                    do_capture = (i_byte != CH_CR) && (i_byte != CH_LF)
                                                     && (r_count < MAX_COUNT);
            default:                    do_capture = 1'b0;
        endcase
    end

    always_comb begin
        n_xor     = r_xor;
        n_star    = r_star;
        n_count   = r_count;
        n_recent0 = r_recent0;
        n_recent1 = r_recent1;
        if (i_valid) begin
            if (is_dollar) begin
                n_xor     = 8'h00;
                n_star    = 1'b0;
                n_count   = '0;
                n_recent0 = 8'h00;
                n_recent1 = 8'h00;
            end else if (do_capture) begin
                n_count   = r_count + CW'(1);
                n_recent0 = i_byte;
                n_recent1 = r_recent0;
                if (!r_star) begin
                    if (i_byte == CH_STAR) begin
                        n_star = 1'b1;
                    end else begin
                        n_xor = r_xor ^ i_byte;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_xor     <= 8'h00;
            r_star    <= 1'b0;
            r_count   <= '0;
            r_recent0 <= 8'h00;
            r_recent1 <= 8'h00;
        end else begin
            r_phase   <= n_phase;
            r_xor     <= n_xor;
            r_star    <= n_star;
            r_count   <= n_count;
            r_recent0 <= n_recent0;
            r_recent1 <= n_recent1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !is_dollar) begin
            case (r_phase)
                PH_TYPE0: r_type0 <= i_byte;
                PH_TYPE1: r_type1 <= i_byte;
                PH_TYPE2: r_type2 <= i_byte;
                default:  r_type0 <= r_type0;
            endcase
        end
    end

    assign hex_hi = hex_value(r_recent1);
    assign hex_lo = hex_value(r_recent0);

    always_comb begin
        o_res_valid = i_valid && !is_dollar && (r_phase == PH_WAIT_LF) && (i_byte == CH_LF);
        o_res.sentence_type     = classify(r_type0, r_type1, r_type2);
        o_res.computed_checksum = r_xor;
        o_res.checksum_ok       = r_star && !hex_hi[4] && !hex_lo[4]
                                  && ({hex_hi[3:0], hex_lo[3:0]} == r_xor);
    end

    `NSFC_ASSERT_NOW(a_count_bound, 1'b1, r_count <= MAX_COUNT)
    `NSFC_ASSERT_NOW(a_result_phase, o_res_valid, r_phase == PH_WAIT_LF)
    `NSFC_ASSERT_NEXT(a_dollar_restart, i_valid && is_dollar,
                      r_phase == PH_TALK1 && r_xor == 8'h00 && !r_star && r_count == '0)

endmodule

`default_nettype wire

@@ sv/nsfc_out_reg.sv @@
// Result holding register between the framer and the output channel.
// Depends on nsfc_pkg and nmea_sentence_framer_checksum_macros.svh.
`default_nettype none

module nsfc_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire nsfc_pkg::t_result i_res,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output logic                   o_free,
    output nsfc_pkg::t_result      o_res
);
    import nsfc_pkg::*;
    `include "nmea_sentence_framer_checksum_macros.svh"

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    `NSFC_ASSERT_NOW(a_load_free, i_load, !r_valid || i_ready)
    `NSFC_ASSERT_NEXT(a_load_shows, i_load, r_valid && r_res == $past(i_res))
    `NSFC_ASSERT_NEXT(a_drain, r_valid && i_ready && !i_load, !r_valid)

endmodule

`default_nettype wire

@@ sv/nmea_sentence_framer_checksum.sv @@
// NMEA sentence framer and checksum checker, top level.
// Depends on nsfc_pkg, nsfc_framer and nsfc_out_reg.
//
// Input channel (i_in_valid / o_in_ready / i_rx_byte): one received character
// per request. Each character updates the framer state in the cycle it is
// accepted. A '$' restarts a sentence, the two talker characters come from
// the configuration registers, and the next three characters give the type.
// Output channel (o_out_valid / i_out_ready): one result per sentence that
// ends in CR followed by LF, holding type, computed XOR and the check flag.
// The result is registered and appears in the cycle after the LF is accepted.
// Throughput: one character per cycle; o_in_ready drops only while a result
// sits in the output register and i_out_ready is low, so a stalled receiver
// holds the input side for as long as it stalls.
// Configuration channel (i_cfg_valid / o_cfg_ready): index 0 writes the first
// talker character, index 1 the second; always ready. The user must write it
// only when idle; the block does not enforce this. Reset (synchronous,
// active low): hunting for '$', talker set to "GP", no pending result.
`default_nettype none

module nmea_sentence_framer_checksum #(
    parameter int MAX_SENTENCE_LENGTH = nsfc_pkg::DEF_MAX_SENTENCE_LENGTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_sentence_type,
    output logic            o_checksum_ok,
    output logic [7:0]      o_computed_checksum,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);
    import nsfc_pkg::*;

    logic [7:0] r_talker_first;
    logic [7:0] r_talker_second;
    logic       in_accept;
    logic       res_valid;
    logic       out_free;
    t_result    res;
    t_result    out_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = out_free;
    assign in_accept   = i_in_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_talker_first  <= TALKER_FIRST_RESET;
            r_talker_second <= TALKER_SECOND_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TALKER_FIRST:  r_talker_first  <= i_cfg_data;
                CFG_TALKER_SECOND: r_talker_second <= i_cfg_data;
                default:           r_talker_first  <= r_talker_first;
            endcase
        end
    end

    nsfc_framer #(
        .MAX_SENTENCE_LENGTH(MAX_SENTENCE_LENGTH)
    ) u_framer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (in_accept),
        .i_byte          (i_rx_byte),
        .i_talker_first  (r_talker_first),
        .i_talker_second (r_talker_second),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    nsfc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_free  (out_free),
        .o_res   (out_res)
    );

    assign o_sentence_type     = out_res.sentence_type;
    assign o_checksum_ok       = out_res.checksum_ok;
    assign o_computed_checksum = out_res.computed_checksum;

endmodule

`default_nettype wire

@@ verif/nsfc_sentence_scoreboard_pkg.sv @@
// Scoreboard for the NMEA sentence framer test: predicts the per-sentence
// result from each accepted character and checks the block's results in order.
// Depends on nsfc_pkg for the phase enum, the result struct and character codes.
package nsfc_sentence_scoreboard_pkg;

    import nsfc_pkg::*;

    class sentence_scoreboard;
        logic [7:0]  talker [2];
        t_phase      phase;
        logic [7:0]  xor_acc;
        bit          star_hit;
        int unsigned char_count;
        logic [7:0]  type_code [3];
        logic [7:0]  last_chars [3];
        t_result     pending_sentences [$];
        int unsigned failures;

        function new();
            talker[0]   = TALKER_FIRST_RESET;
            talker[1]   = TALKER_SECOND_RESET;
            phase       = PH_HUNT;
            xor_acc     = 8'h00;
            star_hit    = 1'b0;
            char_count  = 0;
            type_code   = '{default: 8'h00};
            last_chars  = '{default: 8'h00};
            failures    = 0;
        endfunction

        function void write_talker(logic idx, logic [7:0] data);
            if (idx == CFG_TALKER_FIRST) begin
                talker[0] = data;
            end else begin
                talker[1] = data;
            end
        endfunction

        function void remember(logic [7:0] c);
            last_chars[2] = last_chars[1];
            last_chars[1] = last_chars[0];
            last_chars[0] = c;
        endfunction

        function void absorb(logic [7:0] c);
            if (char_count < 127) begin
                char_count++;
            end
            remember(c);
            if (!star_hit) begin
                if (c == CH_STAR) begin
                    star_hit = 1'b1;
                end else begin
                    xor_acc ^= c;
                end
            end
        endfunction

        // Bit 4 flags a character outside 0-9 and A-F.
        function logic [4:0] nibble_of(logic [7:0] c);
            if (c inside {[CH_0:CH_9]}) begin
                return {1'b0, c[3:0]};
            end
            if (c inside {[CH_A:CH_F]}) begin
                return {1'b0, c[3:0] + 4'd9};
            end
            return 5'h10;
        endfunction

        function logic [1:0] type_of();
            case ({type_code[0], type_code[1], type_code[2]})
                {CH_G, CH_G, CH_A}: return TYPE_GGA;
                {CH_G, CH_S, CH_V}: return TYPE_GSV;
                {CH_R, CH_M, CH_C}: return TYPE_RMC;
                default:            return TYPE_OTHER;
            endcase
        endfunction

        function void take_char(logic [7:0] c);
            t_result    r;
            logic [4:0] hi;
            logic [4:0] lo;
            if (c == CH_DOLLAR) begin
                phase      = PH_TALK1;
                xor_acc    = 8'h00;
                star_hit   = 1'b0;
                char_count = 0;
                last_chars = '{default: 8'h00};
                return;
            end
            case (phase)
                PH_TALK1: begin
                    if (c == talker[0]) begin
                        absorb(c);
                        phase = PH_TALK2;
                    end else begin
                        phase = PH_HUNT;
                    end
                end
                PH_TALK2: begin
                    if (c == talker[1]) begin
                        absorb(c);
                        phase = PH_TYPE0;
                    end else begin
                        phase = PH_HUNT;
                    end
                end
                PH_TYPE0, PH_TYPE1, PH_TYPE2: begin
                    type_code[int'(phase) - int'(PH_TYPE0)] = c;
                    absorb(c);
                    phase = t_phase'(phase + 3'd1);
                end
                PH_BODY: begin
                    if (c == CH_CR) begin
                        remember(c);
                        phase = PH_WAIT_LF;
                    end else if (c == CH_LF || char_count >= DEF_MAX_SENTENCE_LENGTH) begin
                        phase = PH_HUNT;
                    end else begin
                        absorb(c);
                    end
                end
                PH_WAIT_LF: begin
                    phase = PH_HUNT;
                    if (c == CH_LF) begin
                        hi = nibble_of(last_chars[2]);
                        lo = nibble_of(last_chars[1]);
                        r.sentence_type     = type_of();
                        r.checksum_ok       = star_hit && !hi[4] && !lo[4] &&
                                              ({hi[3:0], lo[3:0]} == xor_acc);
                        r.computed_checksum = xor_acc;
                        pending_sentences.push_back(r);
                    end
                end
                default: phase = PH_HUNT;
            endcase
        endfunction

        function void check_result(logic [1:0] st, logic ok, logic [7:0] cs, realtime stamp);
            t_result want;
            if (pending_sentences.size() == 0) begin
                $display("%0.0f ns: unexpected result: type %0d ok %0d checksum %02h",
                         stamp, st, ok, cs);
                failures++;
                return;
            end
            want = pending_sentences.pop_front();
            if (st != want.sentence_type) begin
                $display("%0.0f ns: sentence_type expected %0d actual %0d",
                         stamp, want.sentence_type, st);
                failures++;
            end
            if (ok != want.checksum_ok) begin
                $display("%0.0f ns: checksum_ok expected %0d actual %0d",
                         stamp, want.checksum_ok, ok);
                failures++;
            end
            if (cs != want.computed_checksum) begin
                $display("%0.0f ns: computed_checksum expected %02h actual %02h",
                         stamp, want.computed_checksum, cs);
                failures++;
            end
        endfunction
    endclass

endpackage

@@ verif/nmea_sentence_framer_checksum_test.sv @@
// Top of the NMEA sentence framer test: drives characters, talker writes and
// output backpressure, and checks every result through the sentence scoreboard.
// Depends on nsfc_pkg, nsfc_sentence_scoreboard_pkg and the framer RTL.
module nmea_sentence_framer_checksum_test;

    timeunit 1ns;
    timeprecision 1ps;

    import nsfc_pkg::*;
    import nsfc_sentence_scoreboard_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 500;
    localparam int RANDOM_CHARS  = 2000;
    localparam int PLAN_SIZE     = 6;

    typedef logic [7:0] char_q_t [$];

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [1:0] o_sentence_type;
    logic       o_checksum_ok;
    logic [7:0] o_computed_checksum;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    logic [7:0] i_cfg_data;

    sentence_scoreboard sb;
    bit                 calm;
    int unsigned        chars_sent;
    int unsigned        quiet_cycles;
    logic [7:0]         talk_first;
    logic [7:0]         talk_second;

    // Talker pairs per phase: "GN", extremes, header specials, never-matching '$', reset value.
    logic [7:0] talker_plan [PLAN_SIZE][2] = '{
        '{CH_G, 8'h4E},
        '{8'h00, 8'hFF},
        '{8'hFF, 8'h00},
        '{CH_STAR, CH_CR},
        '{CH_DOLLAR, CH_LF},
        '{CH_G, 8'h50}
    };

    nmea_sentence_framer_checksum DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_rx_byte           (i_rx_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_sentence_type     (o_sentence_type),
        .o_checksum_ok       (o_checksum_ok),
        .o_computed_checksum (o_computed_checksum),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        bit busy;
        if (i_rst_n) begin
            busy = 1'b0;
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_sentence_type, o_checksum_ok, o_computed_checksum, $realtime);
                busy = 1'b1;
            end
            if (i_in_valid && o_in_ready) begin
                sb.take_char(i_rx_byte);
                busy = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_talker(i_cfg_index, i_cfg_data);
                busy = 1'b1;
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Hold off the result side with a random stall per result.
    initial begin
        int unsigned stall;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
        end
    end

    task automatic send_char(logic [7:0] c);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= c;
        do @(posedge i_clk); while (!o_in_ready);
        chars_sent++;
    endtask

    task automatic send_chars(char_q_t q);
        foreach (q[i]) begin
            send_char(q[i]);
        end
    endtask

    task automatic send_text(string s);
        foreach (s[i]) begin
            send_char(s[i]);
        end
    endtask

    // Drop valid, wait for every pending result, then let the block go quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_sentences.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_talker(logic [7:0] first, logic [7:0] second);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_TALKER_FIRST;
        i_cfg_data  <= first;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_TALKER_SECOND;
        i_cfg_data  <= second;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        talk_first  = first;
        talk_second = second;
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n);
        return (n < 4'd10) ? CH_0 + 8'(n) : CH_A + 8'(n - 4'd10);
    endfunction

    function automatic void build_sentence(output char_q_t q);
        logic [7:0]  chk;
        logic [7:0]  c;
        int unsigned body_len;
        q = {};
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
        end
        q.push_back(CH_DOLLAR);
        q.push_back($urandom_range(0, 15) == 0 ? 8'($urandom) : talk_first);
        q.push_back($urandom_range(0, 15) == 0 ? 8'($urandom) : talk_second);
        case ($urandom_range(0, 4))
            0: q = {q, CH_G, CH_G, CH_A};
            1: q = {q, CH_G, CH_S, CH_V};
            2: q = {q, CH_R, CH_M, CH_C};
            3: repeat (3) q.push_back(8'($urandom_range(8'h41, 8'h5A)));
            default: repeat (3) q.push_back(8'($urandom));
        endcase
        body_len = ($urandom_range(0, 6) == 0) ? $urandom_range(68, 80) : $urandom_range(0, 12);
        repeat (body_len) begin
            if ($urandom_range(0, 19) == 0) begin
                c = 8'($urandom);
            end else begin
                c = 8'($urandom_range(8'h20, 8'h7E));
                if (c == CH_DOLLAR || c == CH_STAR) begin
                    c = 8'h2C;
                end
            end
            q.push_back(c);
        end
        chk = 8'h00;
        foreach (q[i]) begin
            if (q[i] == CH_DOLLAR) begin
                chk = 8'h00;
            end else if (q[i] == CH_STAR) begin
                break;
            end else begin
                chk ^= q[i];
            end
        end
        case ($urandom_range(0, 9))
            0: ;
            1: begin
                chk ^= 8'($urandom_range(1, 255));
                q = {q, CH_STAR, hex_char(chk[7:4]), hex_char(chk[3:0])};
            end
            2: q = {q, CH_STAR, hex_char(chk[7:4]) | 8'h20, hex_char(chk[3:0]) | 8'h20};
            3: q = {q, CH_STAR, 8'($urandom), 8'($urandom)};
            default: q = {q, CH_STAR, hex_char(chk[7:4]), hex_char(chk[3:0])};
        endcase
        case ($urandom_range(0, 11))
            0: q = {q, CH_CR, 8'($urandom)};
            1: q.push_back(CH_LF);
            2: q = {q, CH_CR, CH_DOLLAR};
            3: ;
            default: q = {q, CH_CR, CH_LF};
        endcase
    endfunction

    initial begin
        char_q_t     q;
        int unsigned phase_end;
        sb           = new();
        calm         = 1'b0;
        chars_sent   = 0;
        quiet_cycles = 0;
        talk_first   = TALKER_FIRST_RESET;
        talk_second  = TALKER_SECOND_RESET;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_rx_byte   <= 8'h00;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_TALKER_FIRST;
        i_cfg_data  <= 8'h00;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("$GPGGA*56\r\n");
        send_text("$GPGSV\r\n");
        send_text("$GPRMC*4b\r\n");
        send_char(8'h00);
        send_char(8'hFF);

        foreach (talker_plan[p]) begin
            settle();
            set_talker(talker_plan[p][0], talker_plan[p][1]);
            phase_end = chars_sent + RANDOM_CHARS / PLAN_SIZE;
            while (chars_sent < phase_end) begin
                calm = ($urandom_range(0, 4) == 0);
                build_sentence(q);
                send_chars(q);
            end
        end
        calm = 1'b0;
        settle();

        if (sb.pending_sentences.size() != 0) begin
            $display("%0.0f ns: %0d expected results never arrived",
                     $realtime, sb.pending_sentences.size());
            sb.failures++;
        end
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
